// File: rtl/core/amd_pkg.sv
// Shared constants and lane indexes for the affine matrix inverse.
package amd_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COEF_WIDTH_DEF = 32;

	// One divider lane per inverse coefficient.
	localparam int NUM_LANES = 6;

	localparam int LANE_SCALE_X = 0;
	localparam int LANE_SKEW_X  = 1;
	localparam int LANE_TRANS_X = 2;
	localparam int LANE_SKEW_Y  = 3;
	localparam int LANE_SCALE_Y = 4;
	localparam int LANE_TRANS_Y = 5;

endpackage

// File: rtl/core/amd_div_cell.sv
// One restoring-division cell: retires one quotient bit for all six lanes.
module amd_div_cell #(
	parameter int CW = 32,
	parameter int DW = 65
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [amd_pkg::NUM_LANES-1:0][DW-1:0]   r_i,
	input  logic [amd_pkg::NUM_LANES-1:0][CW:0]     nb_i,
	input  logic [amd_pkg::NUM_LANES-1:0][CW:0]     q_i,
	input  logic [amd_pkg::NUM_LANES-1:0]           over_i,
	input  logic [amd_pkg::NUM_LANES-1:0]           neg_i,
	input  logic [DW-1:0]                           d_i,
	input  logic                                    zero_i,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [amd_pkg::NUM_LANES-1:0][DW-1:0]   r_o,
	output logic [amd_pkg::NUM_LANES-1:0][CW:0]     nb_o,
	output logic [amd_pkg::NUM_LANES-1:0][CW:0]     q_o,
	output logic [amd_pkg::NUM_LANES-1:0]           over_o,
	output logic [amd_pkg::NUM_LANES-1:0]           neg_o,
	output logic [DW-1:0]                           d_o,
	output logic                                    zero_o
);
	import amd_pkg::*;

	logic                               v_q;
	logic [NUM_LANES-1:0][DW-1:0]       r_n;
	logic [NUM_LANES-1:0]               ge;
	logic [NUM_LANES-1:0][DW:0]         rs;
	logic [NUM_LANES-1:0][DW:0]         diff;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			rs[l]   = {r_i[l], nb_i[l][CW]};
			ge[l]   = rs[l] >= {1'b0, d_i};
			diff[l] = rs[l] - {1'b0, d_i};
			r_n[l]  = ge[l] ? diff[l][DW-1:0] : rs[l][DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				r_o[l]  <= r_n[l];
				nb_o[l] <= {nb_i[l][CW-1:0], 1'b0};
				q_o[l]  <= {q_i[l][CW-1:0], ge[l]};
			end
			over_o <= over_i;
			neg_o  <= neg_i;
			d_o    <= d_i;
			zero_o <= zero_i;
		end
	end

endmodule

// File: rtl/core/amd_front.sv
// Front pipeline: products, determinant, numerator magnitudes and the overflow check.
module amd_front #(
	parameter int FRAC_BITS  = 16,
	parameter int COEF_WIDTH = 32,
	parameter int DW         = 65
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic signed [COEF_WIDTH-1:0]                scale_x,
	input  logic signed [COEF_WIDTH-1:0]                skew_x,
	input  logic signed [COEF_WIDTH-1:0]                trans_x,
	input  logic signed [COEF_WIDTH-1:0]                skew_y,
	input  logic signed [COEF_WIDTH-1:0]                scale_y,
	input  logic signed [COEF_WIDTH-1:0]                trans_y,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [amd_pkg::NUM_LANES-1:0][DW-1:0]       r_o,
	output logic [amd_pkg::NUM_LANES-1:0][COEF_WIDTH:0] nb_o,
	output logic [amd_pkg::NUM_LANES-1:0]               over_o,
	output logic [amd_pkg::NUM_LANES-1:0]               neg_o,
	output logic [DW-1:0]                               d_o,
	output logic                                        zero_o
);
	import amd_pkg::*;

	localparam int W   = COEF_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int NW  = (2 * W + 1 + F > W + 2 * F) ? 2 * W + 1 + F : W + 2 * F;
	localparam int HW  = NW - W - 1;
	localparam int CMW = (HW > DW) ? HW : DW;

	logic [3:0] v_q;
	logic [3:0] en;

	logic signed [W-1:0]  sx_s1, kx_s1, tx_s1, ky_s1, sy_s1, ty_s1;
	logic signed [W-1:0]  sx_s2, kx_s2, ky_s2, sy_s2;
	logic signed [PW-1:0] p_sxsy_s2, p_kxky_s2, p_kxty_s2, p_sytx_s2, p_kytx_s2, p_sxty_s2;
	logic signed [W-1:0]  sx_s3, kx_s3, ky_s3, sy_s3;
	logic signed [DW-1:0] det_s3, n2_s3, n5_s3;

	logic [W-1:0]                  mag_sx, mag_kx, mag_ky, mag_sy;
	logic [DW-1:0]                 mag_n2, mag_n5, mag_d;
	logic [NUM_LANES-1:0][NW-1:0]  num;
	logic [NUM_LANES-1:0]          neg_n, over_n;
	logic [NUM_LANES-1:0][HW-1:0]  hi;
	logic [NUM_LANES-1:0][DW-1:0]  r_n;

	assign en[3]     = !v_q[3] || out_ready;
	assign en[2]     = !v_q[2] || en[3];
	assign en[1]     = !v_q[1] || en[2];
	assign en[0]     = !v_q[0] || en[1];
	assign in_ready  = en[0];
	assign out_valid = v_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			if (en[1]) v_q[1] <= v_q[0];
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
		end
	end

	// Magnitudes and signs of the six numerators and of the determinant.
	always_comb begin
		mag_sx = sx_s3[W-1] ? (~sx_s3 + 1'b1) : sx_s3;
		mag_kx = kx_s3[W-1] ? (~kx_s3 + 1'b1) : kx_s3;
		mag_ky = ky_s3[W-1] ? (~ky_s3 + 1'b1) : ky_s3;
		mag_sy = sy_s3[W-1] ? (~sy_s3 + 1'b1) : sy_s3;
		mag_n2 = n2_s3[DW-1] ? (~n2_s3 + 1'b1) : n2_s3;
		mag_n5 = n5_s3[DW-1] ? (~n5_s3 + 1'b1) : n5_s3;
		mag_d  = det_s3[DW-1] ? (~det_s3 + 1'b1) : det_s3;

		num[LANE_SCALE_X] = NW'(mag_sy) << (2 * F);
		num[LANE_SKEW_X]  = NW'(mag_kx) << (2 * F);
		num[LANE_TRANS_X] = NW'(mag_n2) << F;
		num[LANE_SKEW_Y]  = NW'(mag_ky) << (2 * F);
		num[LANE_SCALE_Y] = NW'(mag_sx) << (2 * F);
		num[LANE_TRANS_Y] = NW'(mag_n5) << F;

		neg_n[LANE_SCALE_X] = sy_s3[W-1] ^ det_s3[DW-1];
		neg_n[LANE_SKEW_X]  = !kx_s3[W-1] ^ det_s3[DW-1];
		neg_n[LANE_TRANS_X] = n2_s3[DW-1] ^ det_s3[DW-1];
		neg_n[LANE_SKEW_Y]  = !ky_s3[W-1] ^ det_s3[DW-1];
		neg_n[LANE_SCALE_Y] = sx_s3[W-1] ^ det_s3[DW-1];
		neg_n[LANE_TRANS_Y] = n5_s3[DW-1] ^ det_s3[DW-1];

		// A quotient of more than W+1 bits always saturates; the cells only
		// resolve the low W+1 quotient bits.
		for (int l = 0; l < NUM_LANES; l++) begin
			hi[l]     = num[l][NW-1:W+1];
			over_n[l] = CMW'(hi[l]) >= CMW'(mag_d);
			r_n[l]    = over_n[l] ? '0 : DW'(hi[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en[0]) begin
			sx_s1 <= scale_x;
			kx_s1 <= skew_x;
			tx_s1 <= trans_x;
			ky_s1 <= skew_y;
			sy_s1 <= scale_y;
			ty_s1 <= trans_y;
		end
		if (v_q[0] && en[1]) begin
			p_sxsy_s2 <= PW'(sx_s1) * PW'(sy_s1);
			p_kxky_s2 <= PW'(kx_s1) * PW'(ky_s1);
			p_kxty_s2 <= PW'(kx_s1) * PW'(ty_s1);
			p_sytx_s2 <= PW'(sy_s1) * PW'(tx_s1);
			p_kytx_s2 <= PW'(ky_s1) * PW'(tx_s1);
			p_sxty_s2 <= PW'(sx_s1) * PW'(ty_s1);
			sx_s2     <= sx_s1;
			kx_s2     <= kx_s1;
			ky_s2     <= ky_s1;
			sy_s2     <= sy_s1;
		end
		if (v_q[1] && en[2]) begin
			det_s3 <= DW'(p_sxsy_s2) - DW'(p_kxky_s2);
			n2_s3  <= DW'(p_kxty_s2) - DW'(p_sytx_s2);
			n5_s3  <= DW'(p_kytx_s2) - DW'(p_sxty_s2);
			sx_s3  <= sx_s2;
			kx_s3  <= kx_s2;
			ky_s3  <= ky_s2;
			sy_s3  <= sy_s2;
		end
		if (v_q[2] && en[3]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				r_o[l]  <= r_n[l];
				nb_o[l] <= num[l][W:0];
			end
			over_o <= over_n;
			neg_o  <= neg_n;
			d_o    <= mag_d;
			zero_o <= (det_s3 == '0);
		end
	end

endmodule

// File: rtl/core/affine_matrix_invert.sv
// Top level of the pipelined 2x3 affine matrix inverse.
// Pipeline from input acceptance to out_valid:
// four front stages, COEF_WIDTH + 1 division cells, one output register.
// Throughput: one item per cycle; every stage is a register slice, so a stalled output
// only holds the stages behind it that are full, and bubbles close up.
// Reset: arst_n clears all valid flags at once; data registers are not reset.
module affine_matrix_invert #(
	parameter int FRAC_BITS  = amd_pkg::FRAC_BITS_DEF,
	parameter int COEF_WIDTH = amd_pkg::COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COEF_WIDTH-1:0] scale_x,
	input  logic signed [COEF_WIDTH-1:0] skew_x,
	input  logic signed [COEF_WIDTH-1:0] trans_x,
	input  logic signed [COEF_WIDTH-1:0] skew_y,
	input  logic signed [COEF_WIDTH-1:0] scale_y,
	input  logic signed [COEF_WIDTH-1:0] trans_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COEF_WIDTH-1:0] inv_scale_x,
	output logic signed [COEF_WIDTH-1:0] inv_skew_x,
	output logic signed [COEF_WIDTH-1:0] inv_trans_x,
	output logic signed [COEF_WIDTH-1:0] inv_skew_y,
	output logic signed [COEF_WIDTH-1:0] inv_scale_y,
	output logic signed [COEF_WIDTH-1:0] inv_trans_y,
	output logic                         invertible,
	output logic                         saturated
);
	import amd_pkg::*;

	localparam int W  = COEF_WIDTH;
	// The determinant and the translation numerators need 2W+1 signed bits.
	localparam int DW = 2 * W + 1;
	localparam int NC = W + 1;

	// Chain links: index 0 is the front output, index NC the last cell output.
	logic                              c_valid [NC+1];
	logic                              c_ready [NC+1];
	logic [NUM_LANES-1:0][DW-1:0]      c_r     [NC+1];
	logic [NUM_LANES-1:0][W:0]         c_nb    [NC+1];
	logic [NUM_LANES-1:0][W:0]         c_q     [NC+1];
	logic [NUM_LANES-1:0]              c_over  [NC+1];
	logic [NUM_LANES-1:0]              c_neg   [NC+1];
	logic [DW-1:0]                     c_d     [NC+1];
	logic                              c_zero  [NC+1];

	logic                              out_valid_q;
	logic [NUM_LANES-1:0][W-1:0]       res_q;
	logic                              inv_q;
	logic                              sat_q;
	logic [NUM_LANES-1:0][W-1:0]       res_n;
	logic [NUM_LANES-1:0]              sat_lane;
	logic [NUM_LANES-1:0][W:0]         lim;
	logic [NUM_LANES-1:0][W:0]         mag_v;
	logic [W:0]                        neg_lim;
	logic [W:0]                        pos_lim;

	amd_front #(
		.FRAC_BITS  (FRAC_BITS),
		.COEF_WIDTH (COEF_WIDTH),
		.DW         (DW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.scale_x   (scale_x),
		.skew_x    (skew_x),
		.trans_x   (trans_x),
		.skew_y    (skew_y),
		.scale_y   (scale_y),
		.trans_y   (trans_y),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.r_o       (c_r[0]),
		.nb_o      (c_nb[0]),
		.over_o    (c_over[0]),
		.neg_o     (c_neg[0]),
		.d_o       (c_d[0]),
		.zero_o    (c_zero[0])
	);

	// The quotient register starts empty; each cell shifts in one bit.
	assign c_q[0] = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		amd_div_cell #(
			.CW (W),
			.DW (DW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.r_i       (c_r[i]),
			.nb_i      (c_nb[i]),
			.q_i       (c_q[i]),
			.over_i    (c_over[i]),
			.neg_i     (c_neg[i]),
			.d_i       (c_d[i]),
			.zero_i    (c_zero[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.r_o       (c_r[i+1]),
			.nb_o      (c_nb[i+1]),
			.q_o       (c_q[i+1]),
			.over_o    (c_over[i+1]),
			.neg_o     (c_neg[i+1]),
			.d_o       (c_d[i+1]),
			.zero_o    (c_zero[i+1])
		);
	end

	// The output register takes a new item whenever it is empty or being drained.
	assign c_ready[NC] = !out_valid_q || out_ready;

	assign neg_lim = (W + 1)'(1) << (W - 1);
	assign pos_lim = neg_lim - 1'b1;

	// Saturate each quotient to the signed coefficient range and apply its sign.
	// A singular matrix forces every coefficient and the saturation flag to zero.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			lim[l]      = c_neg[NC][l] ? neg_lim : pos_lim;
			sat_lane[l] = !c_zero[NC] && (c_over[NC][l] || (c_q[NC][l] > lim[l]));
			mag_v[l]    = (c_over[NC][l] || (c_q[NC][l] > lim[l])) ? lim[l] : c_q[NC][l];
			if (c_zero[NC]) begin
				res_n[l] = '0;
			end else if (c_neg[NC][l]) begin
				res_n[l] = W'(~mag_v[l] + 1'b1);
			end else begin
				res_n[l] = W'(mag_v[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[NC]) begin
			out_valid_q <= c_valid[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (c_valid[NC] && c_ready[NC]) begin
			res_q <= res_n;
			inv_q <= !c_zero[NC];
			sat_q <= |sat_lane;
		end
	end

	assign out_valid   = out_valid_q;
	assign inv_scale_x = res_q[LANE_SCALE_X];
	assign inv_skew_x  = res_q[LANE_SKEW_X];
	assign inv_trans_x = res_q[LANE_TRANS_X];
	assign inv_skew_y  = res_q[LANE_SKEW_Y];
	assign inv_scale_y = res_q[LANE_SCALE_Y];
	assign inv_trans_y = res_q[LANE_TRANS_Y];
	assign invertible  = inv_q;
	assign saturated   = sat_q;

endmodule
